[rtl/srllt_pkg.sv]
`default_nettype none
package srllt_pkg;
    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int MaxOpenConn = 512;
    localparam int RefW = 10;
    localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_REQUEST = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_TICK = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        V_ALLOW = 3'd0,
        V_REFUSE = 3'd1,
        V_RATE = 3'd2,
        V_FORBID = 3'd3,
        V_FULL = 3'd4,
        V_UNKNOWN = 3'd5
    } t_verdict;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_LOCKOUT = 2'd2;
    localparam logic [1:0] REG_MAXBAD = 2'd3;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic [1:0] opcode;
        logic [31:0] src_addr;
        logic [47:0] now_ms;
        logic auth_ok;
    } t_item;

    // One table entry, minus its valid bit.
    typedef struct packed {
        logic [31:0] src;
        logic [7:0] fail;
        logic [47:0] last;
        logic [47:0] expire;
        logic pend;
        logic [RefW-1:0] refs;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EXEC,
        S_OUT
    } t_state;

    function automatic logic [47:0] deadline(input logic [47:0] now, input logic [21:0] d);
        logic [48:0] t;
        t = {1'b0, now} + {27'd0, d};
        return t[48] ? Mask48 : t[47:0];
    endfunction
endpackage
`default_nettype wire

[rtl/srllt_front.sv]
`default_nettype none
module srllt_front
    import srllt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    output logic o_ready,
    input wire t_item i_item,
    output logic o_valid,
    input wire logic i_ready,
    output t_item o_item
);
    // Two-entry queue between front and back.
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store item
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
    end
endmodule
`default_nettype wire

[rtl/srllt_back.sv]
`default_nettype none
module srllt_back
    import srllt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    output logic o_ready,
    input wire t_item i_item,
    input wire logic [15:0] i_period,
    input wire logic [15:0] i_window,
    input wire logic [21:0] i_lockout,
    input wire logic [7:0] i_maxbad,
    output logic o_valid,
    input wire logic i_ready,
    output logic [2:0] o_verdict,
    output logic [47:0] o_next,
    output logic [6:0] o_count
);
    // Entry table: valid bits in flip-flops, the rest in an array with registered read.
    logic [TableEntries-1:0] r_vld;
    t_entry r_mem [TableEntries];
    t_entry r_rd;

    t_state r_state, n_state;
    t_item r_it;
    logic [IdxW-1:0] r_idx;
    logic r_hit, r_free_ok;
    logic [IdxW-1:0] r_hit_i, r_free_i;
    logic [47:0] r_best;
    logic r_any;
    logic [6:0] r_cnt;
    logic [2:0] r_verdict;

    logic [IdxW-1:0] ci, xi, rd_addr, wr_addr;
    logic scan_last, take_in;
    logic e_vld, e_pend, e_due, e_retire;
    logic [RefW-1:0] e_ref;
    logic [47:0] e_d;
    logic [RefW-1:0] x_ref, x_conn;
    logic x_pend;
    logic [7:0] x_fail;
    logic [47:0] x_last;
    logic x_rate, req_ok, cmp_ok;
    logic wr_en;
    t_entry wr_data, req_data;

    // During the scan r_rd holds entry ci; during execute it holds entry xi.
    assign ci = r_idx;
    assign scan_last = (ci == IdxW'(TableEntries-1));
    assign take_in = (r_state == S_IDLE) && i_valid;
    assign e_vld = r_vld[ci];
    assign e_pend = r_rd.pend;
    assign e_ref = r_rd.refs;
    assign e_due = r_it.now_ms >= r_rd.expire;
    assign e_d = r_rd.expire - r_it.now_ms;
    assign e_retire = (r_state == S_SCAN) && (r_it.opcode == OP_TICK) && e_vld && e_pend
                      && e_due;

    assign xi = r_hit ? r_hit_i : r_free_i;
    assign x_ref = r_hit ? r_rd.refs : '0;
    assign x_pend = r_hit ? r_rd.pend : 1'b0;
    assign x_fail = r_hit ? r_rd.fail : 8'd0;
    assign x_last = r_hit ? r_rd.last : 48'd0;
    assign x_conn = x_ref - {{(RefW-1){1'b0}}, x_pend};
    assign x_rate = {1'b0, r_it.now_ms} < {1'b0, x_last} + {33'd0, i_period};
    assign req_ok = (r_hit || r_free_ok) && x_conn < RefW'(MaxOpenConn);
    assign cmp_ok = r_hit && x_ref > {{(RefW-1){1'b0}}, x_pend};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (scan_last) n_state = (r_it.opcode == OP_TICK) ? S_OUT : S_FETCH;
            S_FETCH: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
        o_verdict = r_verdict;
        o_next = (r_it.opcode == OP_TICK) ? (r_any ? r_best : Mask48) : 48'd0;
        o_count = (r_it.opcode == OP_TICK) ? r_cnt : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Read address: entry 0 ahead of the scan, the next entry during it, the chosen one after
    always_comb begin
        rd_addr = '0;
        if (r_state == S_SCAN) rd_addr = ci + 1'b1;
        else if (r_state == S_FETCH) rd_addr = xi;
    end

    // Scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_it <= i_item;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_free_ok <= 1'b0;
            r_any <= 1'b0;
            r_best <= Mask48;
            r_cnt <= 7'd0;
            r_hit_i <= '0;
            r_free_i <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (e_vld && r_rd.src == r_it.src_addr && !r_hit) begin
                r_hit <= 1'b1;
                r_hit_i <= ci;
            end
            if (!e_vld && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free_i <= ci;
            end
            if (r_it.opcode == OP_TICK && e_vld && e_pend) begin
                if (e_due) begin
                    if (r_cnt != 7'd127) r_cnt <= r_cnt + 7'd1;
                end else if (!r_any || e_d < r_best) begin
                    r_best <= e_d;
                    r_any <= 1'b1;
                end
            end
        end
    end

    // Build the entry written back by a request
    always_comb begin
        req_data.src = r_it.src_addr;
        req_data.fail = x_fail;
        req_data.last = x_last;
        req_data.expire = r_hit ? r_rd.expire : 48'd0;
        req_data.pend = x_pend;
        req_data.refs = x_ref + 1'b1;
        if (!x_rate) begin
            req_data.last = r_it.now_ms;
            if (!x_pend) begin
                req_data.expire = deadline(r_it.now_ms, {6'd0, i_window});
                req_data.pend = 1'b1;
                req_data.refs = x_ref + RefW'(2);
            end
            if (!r_it.auth_ok) begin
                if (x_fail == 8'd0) req_data.expire = deadline(r_it.now_ms, i_lockout);
                if (x_fail != 8'd255) req_data.fail = x_fail + 8'd1;
            end
        end
    end

    // Select the single table write of this cycle
    always_comb begin
        wr_en = 1'b0;
        wr_addr = ci;
        wr_data = r_rd;
        if (e_retire) begin
            // drop the pending reference
            wr_en = 1'b1;
            wr_data.pend = 1'b0;
            wr_data.refs = (e_ref <= RefW'(1)) ? '0 : e_ref - 1'b1;
        end else if (r_state == S_EXEC && r_it.opcode == OP_REQUEST && req_ok) begin
            wr_en = 1'b1;
            wr_addr = xi;
            wr_data = req_data;
        end else if (r_state == S_EXEC && r_it.opcode == OP_COMPLETE && cmp_ok) begin
            wr_en = 1'b1;
            wr_addr = xi;
            wr_data.refs = x_ref - 1'b1;
            if (x_ref == RefW'(1)) wr_data.pend = 1'b0;
        end
    end

    // Entry array
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (e_retire) begin
            if (e_ref <= RefW'(1)) r_vld[ci] <= 1'b0;
        end else if (r_state == S_EXEC && r_it.opcode == OP_REQUEST && req_ok) begin
            r_vld[xi] <= 1'b1;
        end else if (r_state == S_EXEC && r_it.opcode == OP_COMPLETE && cmp_ok) begin
            if (x_ref == RefW'(1)) r_vld[xi] <= 1'b0;
        end
    end

    // Verdict
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC || (r_state == S_SCAN && scan_last)) begin
            r_verdict <= V_ALLOW;
            case (r_it.opcode)
                OP_CHECK: if (r_hit && x_fail >= i_maxbad) r_verdict <= V_REFUSE;
                OP_REQUEST: begin
                    if (!req_ok)
                        r_verdict <= V_FULL;
                    else if (x_rate)
                        r_verdict <= V_RATE;
                    else if (!r_it.auth_ok)
                        r_verdict <= V_FORBID;
                end
                OP_COMPLETE:
                    if (!cmp_ok) r_verdict <= V_UNKNOWN;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/source_rate_limit_lockout_table.sv]
// Channel | Dir | Contents
// s_axis  | in  | tdata: opcode[1:0], src_addr[33:2], now_ms[81:34], auth_ok[82]
// m_axis  | out | tdata: verdict[2:0], next_timeout_ms[50:3], expired_count[57:51]
// cfg     | in  | wr_en, index 0..3, data 22 bits
// A check, request or completion goes from input beat to output beat in these steps: it
// leaves the queue, then a scan of all 64 entries of the table, one entry read, one update and
// the output beat. A tick skips the read and update.
// Reset is synchronous and clears all entry valid bits and the configuration registers to defaults.
// A stalled output holds the back end; the front queue accepts until it holds two beats.
`default_nettype none
module source_rate_limit_lockout_table
    import srllt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input wire logic [87:0] s_axis_tdata, // opcode, src_addr, now_ms, auth_ok
    output logic m_axis_tvalid,
    input wire logic m_axis_tready,
    output logic [63:0] m_axis_tdata, // verdict, next_timeout_ms, expired_count
    input wire logic i_cfg_wr_en,
    input wire logic [1:0] i_cfg_index,
    input wire logic [21:0] i_cfg_data
);
    logic [15:0] r_period, r_window;
    logic [21:0] r_lockout;
    logic [7:0] r_maxbad;
    t_item in_item, q_item;
    logic q_valid, q_ready;
    logic [2:0] verdict;
    logic [47:0] nxt;
    logic [6:0] cnt;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd333;
            r_window <= 16'd1000;
            r_lockout <= 22'd10000;
            r_maxbad <= 8'd3;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PERIOD: r_period <= i_cfg_data[15:0];
                REG_WINDOW: r_window <= i_cfg_data[15:0];
                REG_LOCKOUT: r_lockout <= i_cfg_data;
                REG_MAXBAD: r_maxbad <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign in_item.opcode = s_axis_tdata[1:0];
    assign in_item.src_addr = s_axis_tdata[33:2];
    assign in_item.now_ms = s_axis_tdata[81:34];
    assign in_item.auth_ok = s_axis_tdata[82];

    srllt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    srllt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_period(r_period), .i_window(r_window), .i_lockout(r_lockout),
        .i_maxbad(r_maxbad),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_verdict(verdict), .o_next(nxt), .o_count(cnt)
    );

    assign m_axis_tdata = {6'd0, cnt, nxt, verdict};
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
    import srllt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected contents of one result beat
    typedef struct {
        t_verdict    verdict;
        logic [47:0] wait_ms;
        logic [6:0]  retired;
    } t_answer;

    // One row of the directed table; pinned rows carry a hand-written answer
    typedef struct {
        t_opcode     op;
        logic [31:0] src;
        logic [47:0] now;
        logic        auth;
        bit          pinned;
        t_answer     answer;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;  // opcode, src_addr, now_ms, auth_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // verdict, next_timeout_ms, expired_count
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [21:0] i_cfg_data;

    source_rate_limit_lockout_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow copy of the source table and its settings
    logic [15:0] gap_ms;
    logic [15:0] window_ms;
    logic [21:0] lock_ms;
    logic [7:0]  bad_limit;
    bit          tbl_valid[TableEntries];
    logic [31:0] tbl_src[TableEntries];
    logic [7:0]  tbl_fails[TableEntries];
    logic [47:0] tbl_served[TableEntries];
    logic [47:0] tbl_expire[TableEntries];
    bit          tbl_armed[TableEntries];
    int          tbl_refs[TableEntries];

    t_answer     verdicts_due[$];
    int          mismatches;
    int          quiet_cycles;
    bit          steady;
    bit          hold_go;
    logic [47:0] clock_ms;
    logic [31:0] src_pool[6];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] sat_add(logic [47:0] base, logic [47:0] delta);
        logic [48:0] sum;
        sum = {1'b0, base} + {1'b0, delta};
        return sum[48] ? Mask48 : sum[47:0];
    endfunction

    function automatic int find_source(logic [31:0] src);
        for (int k = 0; k < TableEntries; k++)
            if (tbl_valid[k] && tbl_src[k] == src)
                return k;
        return -1;
    endfunction

    // Drop one reference; free the entry at zero
    function automatic void drop_hold(int k);
        if (tbl_refs[k] > 0)
            tbl_refs[k]--;
        if (tbl_refs[k] == 0) begin
            tbl_valid[k] = 0;
            tbl_armed[k] = 0;
        end
    endfunction

    function automatic t_answer rate_limit_verdict(t_opcode op, logic [31:0] src,
                                                   logic [47:0] now, logic auth);
        t_answer ans;
        int      k;
        bit      take_ref;
        bit      any;
        logic [47:0] best;
        ans.verdict = V_ALLOW;
        ans.wait_ms = '0;
        ans.retired = '0;
        k = find_source(src);
        case (op)
            OP_CHECK: begin
                if (k >= 0 && tbl_fails[k] >= bad_limit)
                    ans.verdict = V_REFUSE;
            end
            OP_REQUEST: begin
                if (k < 0) begin
                    for (int j = 0; j < TableEntries; j++) begin
                        if (!tbl_valid[j]) begin
                            k = j;
                            break;
                        end
                    end
                    if (k >= 0) begin
                        tbl_valid[k] = 1;
                        tbl_src[k] = src;
                        tbl_fails[k] = '0;
                        tbl_served[k] = '0;
                        tbl_expire[k] = '0;
                        tbl_armed[k] = 0;
                        tbl_refs[k] = 0;
                    end
                end
                if (k < 0 || tbl_refs[k] - int'(tbl_armed[k]) >= MaxOpenConn) begin
                    ans.verdict = V_FULL;
                end else begin
                    tbl_refs[k]++;
                    if ({1'b0, now} < {1'b0, tbl_served[k]} + {33'd0, gap_ms}) begin
                        ans.verdict = V_RATE;
                    end else begin
                        tbl_served[k] = now;
                        if (!tbl_armed[k]) begin
                            tbl_expire[k] = sat_add(now, {32'd0, window_ms});
                            tbl_armed[k] = 1;
                            tbl_refs[k]++;
                        end
                        if (!auth) begin
                            take_ref = 1;
                            if (tbl_fails[k] == 0 && tbl_armed[k]) begin
                                tbl_armed[k] = 0;
                                take_ref = 0;
                            end
                            if (!tbl_armed[k]) begin
                                tbl_expire[k] = sat_add(now, {26'd0, lock_ms});
                                tbl_armed[k] = 1;
                                if (take_ref)
                                    tbl_refs[k]++;
                            end
                            if (tbl_fails[k] != 8'hFF)
                                tbl_fails[k]++;
                            ans.verdict = V_FORBID;
                        end
                    end
                end
            end
            OP_COMPLETE: begin
                if (k < 0 || tbl_refs[k] <= int'(tbl_armed[k]))
                    ans.verdict = V_UNKNOWN;
                else
                    drop_hold(k);
            end
            default: begin
                // Retire due expiries, track the nearest remaining one
                any = 0;
                best = Mask48;
                for (int j = 0; j < TableEntries; j++) begin
                    if (!tbl_valid[j] || !tbl_armed[j])
                        continue;
                    if (now >= tbl_expire[j]) begin
                        tbl_armed[j] = 0;
                        drop_hold(j);
                        if (ans.retired != 7'd127)
                            ans.retired++;
                    end else if (!any || tbl_expire[j] - now < best) begin
                        best = tbl_expire[j] - now;
                        any = 1;
                    end
                end
                ans.wait_ms = any ? best : Mask48;
            end
        endcase
        return ans;
    endfunction

    // Offer one beat, predict on acceptance
    task automatic send_item(t_opcode op, logic [31:0] src, logic [47:0] now, logic auth,
                             bit pinned = 0, t_answer pin = '{V_ALLOW, '0, '0});
        t_answer ans;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 37);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, auth, now, src, op};
        do @(posedge i_clk); while (!s_axis_tready);
        ans = rate_limit_verdict(op, src, now, auth);
        verdicts_due.push_back(pinned ? pin : ans);
    endtask

    // Drain the expected results and let the block settle
    task automatic quiesce();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (verdicts_due.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [21:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_PERIOD: gap_ms = value[15:0];
            REG_WINDOW: window_ms = value[15:0];
            REG_LOCKOUT: lock_ms = value;
            REG_MAXBAD: bad_limit = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [15:0] per, logic [15:0] win, logic [21:0] lock,
                              logic [7:0] bad);
        quiesce();
        write_reg(REG_PERIOD, {6'd0, per});
        write_reg(REG_WINDOW, {6'd0, win});
        write_reg(REG_LOCKOUT, lock);
        write_reg(REG_MAXBAD, {14'd0, bad});
    endtask

    // Mostly sources from a small pool and forward-moving time
    task automatic send_random();
        int          pick;
        t_opcode     op;
        logic [31:0] src;
        logic [47:0] now;
        pick = $urandom_range(99);
        op = pick < 20 ? OP_CHECK : pick < 60 ? OP_REQUEST : pick < 85 ? OP_COMPLETE : OP_TICK;
        src = $urandom_range(99) < 85 ? src_pool[$urandom_range(5)] : $urandom;
        pick = $urandom_range(99);
        if (pick < 90) begin
            clock_ms = clock_ms + $urandom_range(400);
            now = clock_ms;
        end else if (pick < 95) begin
            now = clock_ms - $urandom_range(500);
        end else begin
            now = 48'({$urandom, $urandom});
        end
        send_item(op, src, now, $urandom_range(99) < 75);
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 0;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // Compare result beats, watch for a hung handshake
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.verdict = t_verdict'(m_axis_tdata[2:0]);
            got.wait_ms = m_axis_tdata[50:3];
            got.retired = m_axis_tdata[57:51];
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end else begin
                want = verdicts_due.pop_front();
                if (got.verdict != want.verdict || got.wait_ms != want.wait_ms
                        || got.retired != want.retired) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if (quiet_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_row rows[20];
        mismatches = 0;
        quiet_cycles = 0;
        steady = 0;
        hold_go = 0;
        clock_ms = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        gap_ms = 16'd333;
        window_ms = 16'd1000;
        lock_ms = 22'd10000;
        bad_limit = 8'd3;
        for (int k = 0; k < TableEntries; k++) begin
            tbl_valid[k] = 0;
            tbl_armed[k] = 0;
            tbl_refs[k] = 0;
            tbl_fails[k] = '0;
            tbl_served[k] = '0;
            tbl_expire[k] = '0;
            tbl_src[k] = '0;
        end
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 6; k++)
            src_pool[k] = $urandom;

        // Directed: unknown source, fresh entry, lockout, backward time, saturation
        rows[0]  = '{OP_CHECK,    32'h0A00_0001, 48'd0,    1'b1, 1, '{V_ALLOW, '0, '0}};
        rows[1]  = '{OP_TICK,     32'h0,         48'd0,    1'b1, 1, '{V_ALLOW, Mask48, '0}};
        rows[2]  = '{OP_REQUEST,  32'h0A00_0001, 48'd0,    1'b1, 1, '{V_RATE, '0, '0}};
        rows[3]  = '{OP_COMPLETE, 32'h0A00_0002, 48'd0,    1'b1, 1, '{V_UNKNOWN, '0, '0}};
        rows[4]  = '{OP_REQUEST,  32'h0A00_0001, 48'd400,  1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[5]  = '{OP_REQUEST,  32'h0A00_0001, 48'd500,  1'b0, 0, '{V_ALLOW, '0, '0}};
        rows[6]  = '{OP_REQUEST,  32'h0A00_0001, 48'd800,  1'b0, 0, '{V_ALLOW, '0, '0}};
        rows[7]  = '{OP_REQUEST,  32'h0A00_0001, 48'd1200, 1'b0, 0, '{V_ALLOW, '0, '0}};
        rows[8]  = '{OP_REQUEST,  32'h0A00_0001, 48'd1600, 1'b0, 0, '{V_ALLOW, '0, '0}};
        rows[9]  = '{OP_CHECK,    32'h0A00_0001, 48'd1700, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[10] = '{OP_REQUEST,  32'h0A00_0001, 48'd1000, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[11] = '{OP_COMPLETE, 32'h0A00_0001, 48'd1800, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[12] = '{OP_COMPLETE, 32'h0A00_0001, 48'd1800, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[13] = '{OP_TICK,     32'h0,         48'd1900, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[14] = '{OP_REQUEST,  32'hFFFF_FFFF, Mask48,   1'b0, 0, '{V_ALLOW, '0, '0}};
        rows[15] = '{OP_TICK,     32'h0,         Mask48 - 48'd1, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[16] = '{OP_REQUEST,  32'h0000_0000, Mask48 - 48'd1, 1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[17] = '{OP_TICK,     32'h0,         Mask48,   1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[18] = '{OP_COMPLETE, 32'hFFFF_FFFF, Mask48,   1'b1, 0, '{V_ALLOW, '0, '0}};
        rows[19] = '{OP_CHECK,    32'h0000_0000, Mask48,   1'b1, 0, '{V_ALLOW, '0, '0}};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r])
            send_item(rows[r].op, rows[r].src, rows[r].now, rows[r].auth,
                      rows[r].pinned, rows[r].answer);

        // Fill the table past capacity, then release and expire everything
        clock_ms = 48'd5000;
        for (int k = 0; k < 65; k++)
            send_item(OP_REQUEST, 32'h0B00_0000 + k, clock_ms, 1'b1);
        for (int k = 0; k < 65; k++)
            send_item(OP_COMPLETE, 32'h0B00_0000 + k, clock_ms, 1'b1);
        clock_ms = clock_ms + 48'd100000;
        send_item(OP_TICK, 32'h0, clock_ms, 1'b1);

        // Pile connections on one source past the open limit, output held off
        hold_go = 1;
        for (int k = 0; k < 513; k++)
            send_item(OP_REQUEST, 32'hC0A8_0001, clock_ms, 1'($urandom_range(1)));
        send_item(OP_COMPLETE, 32'hC0A8_0001, clock_ms, 1'b1);

        // Random phases across register settings
        set_limits(16'd1, 16'd1, 22'd1, 8'd1);
        repeat (8) send_random();
        steady = 1;
        set_limits(16'hFFFF, 16'hFFFF, 22'h3F_FFFF, 8'hFF);
        repeat (8) send_random();
        steady = 0;
        set_limits(16'd50, 16'd300, 22'd2000, 8'd0);
        repeat (4) send_random();
        quiesce();
        repeat (4) send_random();
        set_limits(16'd200, 16'd800, 22'd5000, 8'd2);
        repeat (8) send_random();

        quiesce();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
